>>> hw/rtl/rqrs_pkg.sv
// Package for the real quadratic root solver: fixed widths, lane indexes,
// status codes and the side structs carried along the pipeline.
// Depends on nothing; the core, front, prep, back and checker files import it.
package rqrs_pkg;

  localparam int unsigned MAG_W   = 32;
  localparam int unsigned PROD_W  = 64;
  localparam int unsigned DM_W    = 66;
  localparam int unsigned ROOT_W  = DM_W / 2;
  localparam int unsigned DEN_W   = 67;
  localparam int unsigned QUO_W   = 33;
  localparam int unsigned NUM_BASE_W = 66;
  localparam int unsigned LANES   = 4;

  localparam int unsigned LANE_R0_RE = 0;
  localparam int unsigned LANE_R0_IM = 1;
  localparam int unsigned LANE_R1_RE = 2;
  localparam int unsigned LANE_R1_IM = 3;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_AZERO = 2'd1,
    STATUS_SAT   = 2'd2
  } status_e;

  typedef struct packed {
    logic azero;
    logic dzero;
    logic dneg;
    logic an;
    logic bn;
    logic cn;
  } flags_t;

  typedef struct packed {
    flags_t             f;
    logic [MAG_W-1:0]   am;
    logic [MAG_W-1:0]   bm;
    logic [MAG_W-1:0]   cm;
    logic [PROD_W-1:0]  b2;
  } sq_side_t;

  typedef struct packed {
    logic             azero;
    logic [LANES-1:0] en;
    logic [LANES-1:0] neg;
  } div_side_t;

endpackage

>>> hw/rtl/rqrs_if.sv
// Valid/ready channel interfaces for the coefficient input and root output.
// Stand-alone; used by the top level and the front and back modules.
interface rqrs_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] coef_a;
  logic signed [31:0] coef_b;
  logic signed [31:0] coef_c;

  modport source (output valid, coef_a, coef_b, coef_c, input ready);
  modport sink (input valid, coef_a, coef_b, coef_c, output ready);
endinterface

interface rqrs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] root0_re;
  logic signed [31:0] root0_im;
  logic signed [31:0] root1_re;
  logic signed [31:0] root1_im;
  logic [1:0]         status;

  modport source (output valid, root0_re, root0_im, root1_re, root1_im, status, input ready);
  modport sink (input valid, root0_re, root0_im, root1_re, root1_im, status, output ready);
endinterface

>>> hw/rtl/real_quadratic_root_solver_core.sv
// Quadratic root solver for signed fixed-point coefficients.
// Inputs pass through the front, square root, case selection, divider and output stages in order.
// Throughput is one item per cycle; the 33-stage square root and the 34-stage
// dividers are fully pipelined, and the whole pipe holds while a result waits.
// Reset is asynchronous, active low, and clears all valid bits.
module real_quadratic_root_solver_core import rqrs_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rqrs_in_if.sink    in_i,
  rqrs_out_if.source out_o
);

  localparam int unsigned NW = NUM_BASE_W + FRAC_BITS;

  logic              en;
  logic              f_valid, s_valid, p_valid, d_valid;
  logic [DM_W-1:0]   dm;
  sq_side_t          f_side, s_side;
  logic [ROOT_W-1:0] s_root;
  logic [NW-1:0]     num [LANES];
  logic [DEN_W-1:0]  den [LANES];
  div_side_t         p_side, d_side;
  logic [QUO_W-1:0]  quo [LANES];
  logic              ovf [LANES];

  rqrs_front u_front (
    .clk_i, .rst_ni, .en_i(en), .in_i,
    .valid_o(f_valid), .dm_o(dm), .side_o(f_side)
  );

  rqrs_sqrt #(.VW(DM_W), .SW($bits(sq_side_t))) u_sqrt (
    .clk_i, .rst_ni, .en_i(en), .valid_i(f_valid), .rad_i(dm), .side_i(f_side),
    .valid_o(s_valid), .root_o(s_root), .side_o(s_side)
  );

  rqrs_prep #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_prep (
    .clk_i, .rst_ni, .en_i(en), .valid_i(s_valid), .s_i(s_root), .side_i(s_side),
    .valid_o(p_valid), .num_o(num), .den_o(den), .side_o(p_side)
  );

  rqrs_div #(.NW(NW), .DW(DEN_W), .QW(QUO_W), .LANES(LANES), .SW($bits(div_side_t)))
    u_div (
    .clk_i, .rst_ni, .en_i(en), .valid_i(p_valid), .num_i(num), .den_i(den),
    .side_i(p_side), .valid_o(d_valid), .quo_o(quo), .ovf_o(ovf), .side_o(d_side)
  );

  rqrs_back u_back (
    .clk_i, .rst_ni, .valid_i(d_valid), .quo_i(quo), .ovf_i(ovf), .side_i(d_side),
    .en_o(en), .out_o
  );

endmodule

>>> hw/rtl/rqrs_front.sv
// Front stages: coefficient magnitudes, products and the exact discriminant.
// Depends on rqrs_pkg and rqrs_in_if.
module rqrs_front import rqrs_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  rqrs_in_if.sink        in_i,
  output logic           valid_o,
  output logic [DM_W-1:0] dm_o,
  output sq_side_t       side_o
);

  logic [MAG_W-1:0]  am_d, bm_d, cm_d;
  logic [PROD_W-1:0] b2_d, ac_d;
  logic              v1_q;
  logic              an_q, bn_q, cn_q;
  logic [MAG_W-1:0]  am_q, bm_q, cm_q;
  logic [PROD_W-1:0] b2_q, ac_q;
  logic [DM_W-1:0]   b2x, ac4, dm_d, dm_q;
  logic              dneg_d, v2_q;
  sq_side_t          side_d, side_q;

  assign in_i.ready = en_i;

  assign am_d = in_i.coef_a[31] ? (~in_i.coef_a + 32'd1) : in_i.coef_a;
  assign bm_d = in_i.coef_b[31] ? (~in_i.coef_b + 32'd1) : in_i.coef_b;
  assign cm_d = in_i.coef_c[31] ? (~in_i.coef_c + 32'd1) : in_i.coef_c;
  assign b2_d = bm_d * bm_d;
  assign ac_d = am_d * cm_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= in_i.valid;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      an_q <= in_i.coef_a[31];
      bn_q <= in_i.coef_b[31];
      cn_q <= in_i.coef_c[31];
      am_q <= am_d;
      bm_q <= bm_d;
      cm_q <= cm_d;
      b2_q <= b2_d;
      ac_q <= ac_d;
    end
  end

  always_comb begin
    b2x = DM_W'(b2_q);
    ac4 = {ac_q, 2'b00};
    if ((an_q == cn_q) || (cm_q == '0)) begin
      dneg_d = b2x < ac4;
      dm_d   = dneg_d ? (ac4 - b2x) : (b2x - ac4);
    end else begin
      dneg_d = 1'b0;
      dm_d   = b2x + ac4;
    end
    side_d.f.azero = (am_q == '0);
    side_d.f.dzero = (dm_d == '0);
    side_d.f.dneg  = dneg_d;
    side_d.f.an    = an_q;
    side_d.f.bn    = bn_q;
    side_d.f.cn    = cn_q;
    side_d.am      = am_q;
    side_d.bm      = bm_q;
    side_d.cm      = cm_q;
    side_d.b2      = b2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dm_q   <= dm_d;
      side_q <= side_d;
    end
  end

  assign valid_o = v2_q;
  assign dm_o    = dm_q;
  assign side_o  = side_q;

endmodule

>>> hw/rtl/rqrs_sqrt.sv
// Pipelined floor square root, one result bit per register stage.
// Depends on nothing; the side vector rides along with each radicand.
module rqrs_sqrt #(
  parameter int unsigned VW = 66,
  parameter int unsigned SW = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [VW-1:0]    rad_i,
  input  logic [SW-1:0]    side_i,
  output logic             valid_o,
  output logic [VW/2-1:0]  root_o,
  output logic [SW-1:0]    side_o
);

  localparam int unsigned RW = VW / 2;

  logic            valid_q [RW];
  logic [RW+1:0]   rem_q   [RW];
  logic [RW-1:0]   res_q   [RW];
  logic [VW-1:0]   rad_q   [RW];
  logic [SW-1:0]   side_q  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic          valid_in;
    logic [RW+1:0] rem_in;
    logic [RW-1:0] res_in;
    logic [VW-1:0] rad_in;
    logic [SW-1:0] side_in;
    logic [RW+3:0] cur, trial;
    logic [RW+1:0] rem_d;
    logic [RW-1:0] res_d;

    if (i == 0) begin : g_first
      assign valid_in = valid_i;
      assign rem_in   = '0;
      assign res_in   = '0;
      assign rad_in   = rad_i;
      assign side_in  = side_i;
    end else begin : g_next
      assign valid_in = valid_q[i-1];
      assign rem_in   = rem_q[i-1];
      assign res_in   = res_q[i-1];
      assign rad_in   = rad_q[i-1];
      assign side_in  = side_q[i-1];
    end

    always_comb begin
      cur   = {rem_in, rad_in[VW-1 -: 2]};
      trial = (RW+4)'({res_in, 2'b01});
      if (cur >= trial) begin
        rem_d = (RW+2)'(cur - trial);
        res_d = {res_in[RW-2:0], 1'b1};
      end else begin
        rem_d = (RW+2)'(cur);
        res_d = {res_in[RW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[i] <= 1'b0;
      end else if (en_i) begin
        valid_q[i] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i]  <= rem_d;
        res_q[i]  <= res_d;
        rad_q[i]  <= rad_in << 2;
        side_q[i] <= side_in;
      end
    end
  end

  assign valid_o = valid_q[RW-1];
  assign root_o  = res_q[RW-1];
  assign side_o  = side_q[RW-1];

endmodule

>>> hw/rtl/rqrs_prep.sv
// Case selection: extra products, then the numerator, divisor and sign of
// each of the four root parts. Depends on rqrs_pkg.
module rqrs_prep import rqrs_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned NW = 82
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [ROOT_W-1:0] s_i,
  input  sq_side_t          side_i,
  output logic              valid_o,
  output logic [NW-1:0]     num_o [LANES],
  output logic [DEN_W-1:0]  den_o [LANES],
  output div_side_t         side_o
);

  logic                  v1_q, v2_q;
  logic [ROOT_W-1:0]     s_q;
  sq_side_t              sd_q;
  logic [2*ROOT_W-1:0]   ss_q;
  logic [MAG_W+MAG_W:0]  cb_q;
  logic [2*ROOT_W-1:0]   cs_q;
  logic [MAG_W:0]        cm2_d, cm2_q;

  logic [MAG_W:0]        twoa;
  logic [ROOT_W:0]       q2m;
  logic [DEN_W-1:0]      dg;
  logic [NW-1:0]         nb, ns, nq, nc, ncb, ncs;
  logic                  bp, bmz;
  logic [NW-1:0]         num_d [LANES];
  logic [DEN_W-1:0]      den_d [LANES];
  div_side_t             ds_d;

  assign cm2_d = {side_i.cm, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q   <= s_i;
      sd_q  <= side_i;
      cm2_q <= cm2_d;
      ss_q  <= s_i * s_i;
      cb_q  <= cm2_d * side_i.bm;
      cs_q  <= cm2_d * s_i;
    end
  end

  always_comb begin
    twoa = {sd_q.am, 1'b0};
    q2m  = (ROOT_W+1)'(sd_q.bm) + (ROOT_W+1)'(s_q);
    dg   = DEN_W'(sd_q.b2) + DEN_W'(ss_q);
    nb   = NW'(sd_q.bm) << FRAC_BITS;
    ns   = NW'(s_q) << FRAC_BITS;
    nq   = NW'(q2m) << FRAC_BITS;
    nc   = NW'(cm2_q) << FRAC_BITS;
    ncb  = NW'(cb_q) << FRAC_BITS;
    ncs  = NW'(cs_q) << FRAC_BITS;
    bp   = !sd_q.f.bn;
    bmz  = (sd_q.bm == '0);

    for (int l = 0; l < LANES; l++) begin
      num_d[l] = nb;
      den_d[l] = DEN_W'(twoa);
    end
    ds_d.azero = sd_q.f.azero;
    ds_d.neg   = {LANES{bp ^ sd_q.f.an}};
    ds_d.en[LANE_R0_RE] = sd_q.f.dzero || !bmz || !sd_q.f.dneg;
    ds_d.en[LANE_R1_RE] = sd_q.f.dzero || !bmz || !sd_q.f.dneg;
    ds_d.en[LANE_R0_IM] = !sd_q.f.dzero && sd_q.f.dneg;
    ds_d.en[LANE_R1_IM] = !sd_q.f.dzero && sd_q.f.dneg;

    if (sd_q.f.dzero) begin
      num_d[LANE_R0_RE] = nb;
      num_d[LANE_R1_RE] = nb;
    end else if (bmz) begin
      for (int l = 0; l < LANES; l++) begin
        num_d[l] = ns;
      end
      ds_d.neg[LANE_R0_RE] = sd_q.f.an;
      ds_d.neg[LANE_R0_IM] = sd_q.f.an;
      ds_d.neg[LANE_R1_RE] = !sd_q.f.an;
      ds_d.neg[LANE_R1_IM] = !sd_q.f.an;
    end else if (!sd_q.f.dneg) begin
      num_d[LANE_R0_RE]     = nq;
      num_d[LANE_R1_RE]     = nc;
      den_d[LANE_R1_RE]     = DEN_W'(q2m);
      ds_d.neg[LANE_R1_RE]  = sd_q.f.cn ^ bp;
    end else begin
      num_d[LANE_R0_RE]     = nb;
      num_d[LANE_R0_IM]     = ns;
      num_d[LANE_R1_RE]     = ncb;
      num_d[LANE_R1_IM]     = ncs;
      den_d[LANE_R1_RE]     = dg;
      den_d[LANE_R1_IM]     = dg;
      ds_d.neg[LANE_R1_RE]  = sd_q.f.cn ^ bp;
      ds_d.neg[LANE_R1_IM]  = sd_q.f.cn == bp;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_o  <= num_d;
      den_o  <= den_d;
      side_o <= ds_d;
    end
  end

  assign valid_o = v2_q;

endmodule

>>> hw/rtl/rqrs_div.sv
// Pipelined restoring divider over several lanes, one quotient bit per stage
// after a range check stage. Depends on nothing.
module rqrs_div #(
  parameter int unsigned NW = 82,
  parameter int unsigned DW = 67,
  parameter int unsigned QW = 33,
  parameter int unsigned LANES = 4,
  parameter int unsigned SW = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [NW-1:0] num_i [LANES],
  input  logic [DW-1:0] den_i [LANES],
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] quo_o [LANES],
  output logic          ovf_o [LANES],
  output logic [SW-1:0] side_o
);

  localparam int unsigned HW = NW - QW;
  localparam int unsigned CW = (HW > DW) ? HW : DW;

  logic          valid_q [QW+1];
  logic [SW-1:0] side_q  [QW+1];
  logic [DW-1:0] rem_q   [QW+1][LANES];
  logic [DW-1:0] den_q   [QW+1][LANES];
  logic [QW-1:0] nlo_q   [QW+1][LANES];
  logic [QW-1:0] quo_q   [QW+1][LANES];
  logic          ovf_q   [QW+1][LANES];

  for (genvar s = 0; s <= QW; s++) begin : g_stage
    logic          valid_in;
    logic [SW-1:0] side_in;

    if (s == 0) begin : g_in
      assign valid_in = valid_i;
      assign side_in  = side_i;
    end else begin : g_chain
      assign valid_in = valid_q[s-1];
      assign side_in  = side_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        side_q[s] <= side_in;
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [DW-1:0] rem_d, den_d;
      logic [QW-1:0] nlo_d, quo_d;
      logic          ovf_d;

      if (s == 0) begin : g_pre
        logic [HW-1:0] hi;
        assign hi = num_i[l][NW-1:QW];
        always_comb begin
          ovf_d = CW'(hi) >= CW'(den_i[l]);
          rem_d = DW'(hi);
          den_d = den_i[l];
          nlo_d = num_i[l][QW-1:0];
          quo_d = '0;
        end
      end else begin : g_step
        logic [DW:0] cur, dex;
        always_comb begin
          cur   = {rem_q[s-1][l], nlo_q[s-1][l][QW-1]};
          dex   = {1'b0, den_q[s-1][l]};
          den_d = den_q[s-1][l];
          nlo_d = nlo_q[s-1][l] << 1;
          ovf_d = ovf_q[s-1][l];
          if (cur >= dex) begin
            rem_d = DW'(cur - dex);
            quo_d = {quo_q[s-1][l][QW-2:0], 1'b1};
          end else begin
            rem_d = DW'(cur);
            quo_d = {quo_q[s-1][l][QW-2:0], 1'b0};
          end
        end
      end

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          rem_q[s][l] <= rem_d;
          den_q[s][l] <= den_d;
          nlo_q[s][l] <= nlo_d;
          quo_q[s][l] <= quo_d;
          ovf_q[s][l] <= ovf_d;
        end
      end
    end
  end

  assign valid_o = valid_q[QW];
  assign side_o  = side_q[QW];
  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign quo_o[l] = quo_q[QW][l];
    assign ovf_o[l] = ovf_q[QW][l];
  end

endmodule

>>> hw/rtl/rqrs_back.sv
// Output stage: signs, saturation, status and the output register that also
// sets the pipeline advance. Depends on rqrs_pkg and rqrs_out_if.
module rqrs_back import rqrs_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic [QUO_W-1:0] quo_i [LANES],
  input  logic             ovf_i [LANES],
  input  div_side_t        side_i,
  output logic             en_o,
  rqrs_out_if.source       out_o
);

  function automatic logic [32:0] sat32(input logic neg, input logic ovf,
                                        input logic [QUO_W-1:0] q);
    logic [32:0] r;
    if (!neg) begin
      if (ovf || (q > 33'h07FFFFFFF)) r = {1'b1, 32'h7FFFFFFF};
      else r = {1'b0, q[31:0]};
    end else begin
      if (ovf || (q > 33'h080000000)) r = {1'b1, 32'h80000000};
      else r = {1'b0, ~q[31:0] + 32'd1};
    end
    return r;
  endfunction

  logic        valid_q;
  logic [31:0] part_d [LANES];
  logic [31:0] part_q [LANES];
  logic [LANES-1:0] flag;
  status_e     status_d, status_q;
  logic [32:0] sr [LANES];

  assign en_o = !valid_q || out_o.ready;

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sr[l]     = sat32(side_i.neg[l], ovf_i[l], quo_i[l]);
      flag[l]   = side_i.en[l] && sr[l][32];
      part_d[l] = (side_i.en[l] && !side_i.azero) ? sr[l][31:0] : 32'd0;
    end
    if (side_i.azero) status_d = STATUS_AZERO;
    else if (flag != '0) status_d = STATUS_SAT;
    else status_d = STATUS_OK;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      part_q   <= part_d;
      status_q <= status_d;
    end
  end

  assign out_o.valid    = valid_q;
  assign out_o.root0_re = part_q[LANE_R0_RE];
  assign out_o.root0_im = part_q[LANE_R0_IM];
  assign out_o.root1_re = part_q[LANE_R1_RE];
  assign out_o.root1_im = part_q[LANE_R1_IM];
  assign out_o.status   = status_q;

endmodule

>>> hw/rtl/rqrs_checker.sv
// Port-level checks on the result channel of the root solver.
// Depends on rqrs_pkg; bound to real_quadratic_root_solver_core below.
module rqrs_checker import rqrs_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] root0_re_i,
  input logic [31:0] root0_im_i,
  input logic [31:0] root1_re_i,
  input logic [31:0] root1_im_i,
  input logic [1:0]  status_i
);

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result valid dropped before its transfer");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(root0_re_i) && $stable(root0_im_i) &&
      $stable(root1_re_i) && $stable(root1_im_i) && $stable(status_i))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result valid during reset");

  a_azero_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STATUS_AZERO |-> root0_re_i == '0 && root0_im_i == '0 &&
      root1_re_i == '0 && root1_im_i == '0)
    else $error("zero leading coefficient gave nonzero roots");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i == STATUS_SAT |->
      root0_re_i == 32'h7FFFFFFF || root0_re_i == 32'h80000000 ||
      root0_im_i == 32'h7FFFFFFF || root0_im_i == 32'h80000000 ||
      root1_re_i == 32'h7FFFFFFF || root1_re_i == 32'h80000000 ||
      root1_im_i == 32'h7FFFFFFF || root1_im_i == 32'h80000000)
    else $error("saturation status without a saturated part");

endmodule

bind real_quadratic_root_solver_core rqrs_checker u_rqrs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .root0_re_i  (out_o.root0_re),
  .root0_im_i  (out_o.root0_im),
  .root1_re_i  (out_o.root1_re),
  .root1_im_i  (out_o.root1_im),
  .status_i    (out_o.status)
);

>>> bench/tb_real_quadratic_root_solver_core.sv
// Self-checking bench for the real quadratic root solver core.
// Predicts roots and status per coefficient set with exact wide arithmetic.
// Depends on rqrs_pkg, rqrs_if and the core RTL.
module tb_real_quadratic_root_solver_core;
  import rqrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FB = 16;
  localparam int WATCH_LIMIT = 20000;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } coefs_t;

  typedef struct packed {
    logic [31:0] r0re;
    logic [31:0] r0im;
    logic [31:0] r1re;
    logic [31:0] r1im;
    status_e     st;
  } roots_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;

  rqrs_in_if  in_ch ();
  rqrs_out_if out_ch ();

  real_quadratic_root_solver_core #(.FRAC_BITS(FB)) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  coefs_t pending_q[$];
  roots_t expected_roots_q[$];
  int     errors = 0;
  int     send_idle_pct = 0;
  int     recv_stall_pct = 0;
  bit     hold_send = 1'b0;
  int     quiet_cycles = 0;

  task automatic report(input string msg);
    $display("ERROR %0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic logic [31:0] saturate(input bit neg, input logic [127:0] m,
                                           inout bit sat);
    if (!neg) begin
      if (m > 128'h7FFF_FFFF) begin
        sat = 1'b1;
        return 32'h7FFF_FFFF;
      end
      return m[31:0];
    end
    if (m > 128'h8000_0000) begin
      sat = 1'b1;
      return 32'h8000_0000;
    end
    return 32'd0 - m[31:0];
  endfunction

  function automatic logic [127:0] quot(input logic [127:0] n, input logic [127:0] d);
    if (d == 0) return '1;
    return n / d;
  endfunction

  function automatic logic [127:0] isqrt(input logic [127:0] v);
    logic [127:0] r;
    logic [127:0] t;
    r = 0;
    for (int k = 34; k >= 0; k--) begin
      t = r | (128'd1 << k);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic roots_t solve_roots(input coefs_t x);
    roots_t       y;
    bit           an, bn, cn, dneg, sat, bp;
    logic [127:0] am, bm, cm, b2, ac4, dm, twoa, s, m, q2m, den;
    y = '0;
    sat = 1'b0;
    an = x.a[31];
    bn = x.b[31];
    cn = x.c[31];
    am = an ? 128'(-64'(x.a)) : 128'(x.a);
    bm = bn ? 128'(-64'(x.b)) : 128'(x.b);
    cm = cn ? 128'(-64'(x.c)) : 128'(x.c);
    if (am == 0) begin
      y.st = STATUS_AZERO;
      return y;
    end
    b2 = bm * bm;
    ac4 = (am * cm) << 2;
    if (an == cn || cm == 0) begin
      dneg = b2 < ac4;
      dm = dneg ? ac4 - b2 : b2 - ac4;
    end else begin
      dneg = 1'b0;
      dm = b2 + ac4;
    end
    twoa = am * 2;
    bp = !bn;
    if (dm == 0) begin
      y.r0re = saturate(bp != an, quot(bm << FB, twoa), sat);
      y.r1re = y.r0re;
    end else begin
      s = isqrt(dm);
      if (bm == 0) begin
        m = quot(s << FB, twoa);
        if (!dneg) begin
          y.r0re = saturate(an, m, sat);
          y.r1re = saturate(!an, m, sat);
        end else begin
          y.r0im = saturate(an, m, sat);
          y.r1im = saturate(!an, m, sat);
        end
      end else if (!dneg) begin
        q2m = bm + s;
        y.r0re = saturate(bp != an, quot(q2m << FB, twoa), sat);
        y.r1re = saturate(cn != bp, quot((cm * 2) << FB, q2m), sat);
      end else begin
        den = b2 + s * s;
        y.r0re = saturate(bp != an, quot(bm << FB, twoa), sat);
        y.r0im = saturate(bp != an, quot(s << FB, twoa), sat);
        y.r1re = saturate(cn != bp, quot((cm * 2 * bm) << FB, den), sat);
        y.r1im = saturate(cn != !bp, quot((cm * 2 * s) << FB, den), sat);
      end
    end
    y.st = sat ? STATUS_SAT : STATUS_OK;
    return y;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid  <= 1'b0;
      in_ch.coef_a <= '0;
      in_ch.coef_b <= '0;
      in_ch.coef_c <= '0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) expected_roots_q.push_back(
          solve_roots('{in_ch.coef_a, in_ch.coef_b, in_ch.coef_c}));
      if (pending_q.size() > 0 && !hold_send &&
          $urandom_range(99) >= send_idle_pct) begin
        coefs_t nx;
        nx = pending_q.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.coef_a <= nx.a;
        in_ch.coef_b <= nx.b;
        in_ch.coef_c <= nx.c;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_roots_q.size() == 0) begin
          report("result transfer with no expected roots");
        end else begin
          roots_t e;
          e = expected_roots_q.pop_front();
          if (out_ch.root0_re !== e.r0re)
            report($sformatf("root0_re %h exp %h", out_ch.root0_re, e.r0re));
          if (out_ch.root0_im !== e.r0im)
            report($sformatf("root0_im %h exp %h", out_ch.root0_im, e.r0im));
          if (out_ch.root1_re !== e.r1re)
            report($sformatf("root1_re %h exp %h", out_ch.root1_re, e.r1re));
          if (out_ch.root1_im !== e.r1im)
            report($sformatf("root1_im %h exp %h", out_ch.root1_im, e.r1im));
          if (out_ch.status !== e.st)
            report($sformatf("status %0d exp %0d", out_ch.status, e.st));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCH_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return 32'($signed($urandom_range(8 << FB)) - (4 << FB));
      4: return 32'($signed($urandom_range(1 << 12)) - (1 << 11));
      default: return $urandom();
    endcase
  endfunction

  task automatic add_set(input int a, input int b, input int c);
    pending_q.push_back('{32'(a), 32'(b), 32'(c)});
  endtask

  task automatic add_random(input int n);
    int a, b, c, r;
    for (int k = 0; k < n; k++) begin
      a = pick_value();
      b = pick_value();
      c = pick_value();
      if (a == 0 && $urandom_range(3) != 0) a = 1 << FB;
      if ($urandom_range(9) == 0) begin
        r = $signed($urandom_range(200)) - 100;
        b = -2 * r * a;
        c = r * r * a;
      end
      if ($urandom_range(12) == 0) b = 0;
      add_set(a, b, c);
    end
  endtask

  task automatic drain();
    while (pending_q.size() > 0 || in_ch.valid || expected_roots_q.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic drain_outputs_only();
    while (in_ch.valid || expected_roots_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    localparam int ONE = 1 << FB;
    #1 rst_ni = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_set(0, ONE, ONE);
    add_set(0, 0, 0);
    add_set(ONE, -2 * ONE, ONE);
    add_set(ONE, 2 * ONE, ONE);
    add_set(ONE, 0, -4 * ONE);
    add_set(ONE, 0, 4 * ONE);
    add_set(-ONE, 0, 4 * ONE);
    add_set(ONE, -3 * ONE, 2 * ONE);
    add_set(ONE, ONE, ONE);
    add_set(-ONE, 3 * ONE, -ONE);
    add_set(ONE, 5 * ONE, 0);
    add_set(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_set(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_set(1, 32'h7FFF_FFFF, 32'h8000_0000);
    add_set(1, 0, 32'h7FFF_FFFF);
    add_set(1, 0, 32'h8000_0000);
    add_set(32'h8000_0000, 0, 0);
    add_set(-1, -1, -1);
    add_set(1, 2, 1);
    add_set(ONE, 32'h8000_0000, 1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1 || ph == 3) ? (ph == 1 ? 88 : 32) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 88 : 32) : 0;
      add_random(160);
      repeat (60) @(posedge clk_i);
      hold_send = 1'b1;
      drain_outputs_only();
      hold_send = 1'b0;
      drain();
    end
    send_idle_pct = 0;
    recv_stall_pct = 0;
    add_random(30);
    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/rqrs_pkg.sv
hw/rtl/rqrs_if.sv
hw/rtl/rqrs_front.sv
hw/rtl/rqrs_sqrt.sv
hw/rtl/rqrs_prep.sv
hw/rtl/rqrs_div.sv
hw/rtl/rqrs_back.sv
hw/rtl/real_quadratic_root_solver_core.sv
hw/rtl/rqrs_checker.sv
bench/tb_real_quadratic_root_solver_core.sv
